FILE: rtl/ptt_pkg.sv
// Package: shared types and constants for the periodic timer table.
`default_nettype none
package ptt_pkg;
  localparam int SLOTS = 16;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SCHED  = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;   // unknown kind, ignored

  localparam logic [2:0] EV_FIRED     = 3'd0;
  localparam logic [2:0] EV_DONE      = 3'd1;
  localparam logic [2:0] EV_SCHEDULED = 3'd2;
  localparam logic [2:0] EV_FULL      = 3'd3;
  localparam logic [2:0] EV_CANCELLED = 3'd4;
  localparam logic [2:0] EV_NOTFOUND  = 3'd5;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [23:0] interval;
    logic [31:0] deadline;
    logic [15:0] runs;
  } slot_t;

  // Op held for the whole scan and applied at the ring head as the slots rotate past.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic [31:0] new_id;
    logic [23:0] interval;
    logic [15:0] runs;
    logic [31:0] cancel_id;
    logic        done;     // schedule/cancel already matched a slot
  } op_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] id;
    logic [15:0] runs_left;
  } cell_res_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINAL, ST_OUT} state_t;
endpackage
`default_nettype wire

FILE: rtl/ptt_cell.sv
// Cell: one slot register with the tick/schedule/cancel update for that slot.
`default_nettype none
module ptt_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire logic            act,
  input  wire ptt_pkg::op_t    op,
  input  wire ptt_pkg::slot_t  slot_in,
  output ptt_pkg::slot_t       slot_out,
  output ptt_pkg::slot_t       slot_q,
  output ptt_pkg::cell_res_t   res,
  output logic                 hit
);
  ptt_pkg::slot_t cur;
  logic [31:0] diff;
  logic due;

  always_comb begin
    cur = slot_q;
    res = '0;
    hit = 1'b0;
    diff = op.now - slot_q.deadline;
    due = slot_q.valid && !diff[31];
    if (act) begin
      unique case (op.kind)
        ptt_pkg::KIND_TICK: begin
          if (due) begin
            cur.deadline = slot_q.deadline + {8'd0, slot_q.interval};
            res.fire = 1'b1;
            res.id = slot_q.id;
            if (slot_q.runs != 16'd0) begin
              cur.runs = slot_q.runs - 16'd1;
              res.runs_left = cur.runs;
              if (cur.runs == 16'd0) cur.valid = 1'b0;
            end
          end
        end
        ptt_pkg::KIND_SCHED: begin
          if (!op.done && !slot_q.valid) begin
            hit = 1'b1;
            cur.valid = 1'b1;
            cur.id = op.new_id;
            cur.interval = op.interval;
            cur.deadline = op.now + {8'd0, op.interval};
            cur.runs = op.runs;
          end
        end
        ptt_pkg::KIND_CANCEL: begin
          if (!op.done && slot_q.valid && slot_q.id == op.cancel_id) begin
            hit = 1'b1;
            cur.valid = 1'b0;
          end
        end
        default: ;
      endcase
    end
    slot_out = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) slot_q.valid <= 1'b0;
    else if (shift) slot_q <= slot_in;
  end
endmodule
`default_nettype wire

FILE: rtl/periodic_task_timer_table.sv
// Top level: periodic timer table built as a rotating ring of slot cells.
// Tick: fired events stream out during the scan, then a tick-done result;
//   schedule/cancel: one result at the end of the scan.
// A new item is taken only in idle, once one full ring rotation through
//   the single active cell at the ring head has finished the last one.
// Reset (rst, synchronous): all slots invalid, now and next id zero, idle.
`default_nettype none
module periodic_task_timer_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [23:0] interval_ms,
  input  wire logic [15:0] run_count,
  input  wire logic [31:0] cancel_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_res,
  output logic [31:0]      result_id,
  output logic [15:0]      runs_left,
  output logic             last
);
  localparam int CW = $clog2(ptt_pkg::SLOTS + 1);

  ptt_pkg::state_t state, state_next;
  ptt_pkg::op_t op;
  logic [31:0] now_ticks, next_id;
  logic [CW-1:0] cnt;

  // Ring: cell k feeds cell k+1, the last cell wraps to cell 0. Only cell 0
  // applies the op, so slots pass the head as cell 0, then cells SLOTS-1 down to 1.
  ptt_pkg::slot_t slot_q [ptt_pkg::SLOTS];
  ptt_pkg::slot_t slot_o [ptt_pkg::SLOTS];
  ptt_pkg::cell_res_t res [ptt_pkg::SLOTS];
  logic hit [ptt_pkg::SLOTS];
  logic shift;

  genvar g;
  generate
    for (g = 0; g < ptt_pkg::SLOTS; g++) begin : g_cell
      ptt_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift), .act(g == 0),
        .op(op),
        .slot_in(slot_o[(g + ptt_pkg::SLOTS - 1) % ptt_pkg::SLOTS]),
        .slot_out(slot_o[g]), .slot_q(slot_q[g]), .res(res[g]), .hit(hit[g])
      );
    end
  endgenerate

  logic out_free;
  assign out_free = !out_valid || out_ready;
  // Stall the rotation while a fired event can't be staged.
  assign shift = (state == ptt_pkg::ST_SCAN) && (!res[0].fire || out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      ptt_pkg::ST_IDLE:
        if (in_valid && kind != ptt_pkg::KIND_NOP) state_next = ptt_pkg::ST_SCAN;
      ptt_pkg::ST_SCAN:
        if (shift && cnt == CW'(ptt_pkg::SLOTS - 1)) state_next = ptt_pkg::ST_FINAL;
      ptt_pkg::ST_FINAL:
        if (out_free) state_next = ptt_pkg::ST_IDLE;
      default: state_next = ptt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ptt_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptt_pkg::ST_IDLE;
      now_ticks <= '0;
      next_id <= '0;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ptt_pkg::ST_IDLE && in_valid) begin
        cnt <= '0;
        op.kind <= kind;
        op.interval <= interval_ms;
        op.runs <= run_count;
        op.cancel_id <= cancel_id;
        op.new_id <= next_id + 32'd1;
        op.done <= 1'b0;
        op.now <= (kind == ptt_pkg::KIND_TICK) ? now_ticks + 32'd1 : now_ticks;
        if (kind == ptt_pkg::KIND_TICK) now_ticks <= now_ticks + 32'd1;
      end
      if (shift) begin
        cnt <= cnt + CW'(1);
        if (hit[0]) op.done <= 1'b1;
      end
      // Output register: load a fired event, load the closing result, or drain.
      if (shift && res[0].fire) begin
        out_valid <= 1'b1;
        event_res <= ptt_pkg::EV_FIRED;
        result_id <= res[0].id;
        runs_left <= res[0].runs_left;
        last <= 1'b0;
      end else if (state == ptt_pkg::ST_FINAL && out_free) begin
        out_valid <= 1'b1;
        runs_left <= '0;
        last <= 1'b1;
        unique case (op.kind)
          ptt_pkg::KIND_TICK: begin
            event_res <= ptt_pkg::EV_DONE;
            result_id <= '0;
          end
          ptt_pkg::KIND_SCHED: begin
            if (op.done) begin
              event_res <= ptt_pkg::EV_SCHEDULED;
              result_id <= op.new_id;
              next_id <= op.new_id;
            end else begin
              event_res <= ptt_pkg::EV_FULL;
              result_id <= '0;
            end
          end
          default: begin
            if (op.done) begin
              event_res <= ptt_pkg::EV_CANCELLED;
              result_id <= op.cancel_id;
            end else begin
              event_res <= ptt_pkg::EV_NOTFOUND;
              result_id <= '0;
            end
          end
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ptt_checker.sv
// Checker: port-level properties of the timer table, bound to the top level.
`default_nettype none
module ptt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  kind,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  event_res,
  input wire logic [31:0] result_id,
  input wire logic [15:0] runs_left,
  input wire logic        last
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(result_id))
    else $error("output changed while stalled");
  a_last_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (event_res != ptt_pkg::EV_FIRED)))
    else $error("last flag mismatch");
  a_runs_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != ptt_pkg::EV_FIRED |-> runs_left == 16'd0)
    else $error("runs_left nonzero on status");
  // An ignored kind leaves the table idle; every other transfer starts a scan.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind != ptt_pkg::KIND_NOP |=> !in_ready)
    else $error("accepted while busy");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= ptt_pkg::EV_NOTFOUND)
    else $error("bad event code");
endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (.*);
`default_nettype wire

FILE: sim/tb_periodic_task_timer_table.sv
// Testbench for the periodic timer table: random and directed items, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module tb_periodic_task_timer_table;

  // One expected result of the table.
  typedef struct packed {
    logic [2:0]  ev;
    logic [31:0] id;
    logic [15:0] runs;
    logic        lst;
  } timer_res_t;

  // Scoreboard: shadow copy of the timer table plus the queue of pending results.
  class timer_scoreboard;
    bit          vld[ptt_pkg::SLOTS];
    bit [31:0]   sid[ptt_pkg::SLOTS];
    bit [23:0]   ival[ptt_pkg::SLOTS];
    bit [31:0]   dline[ptt_pkg::SLOTS];
    bit [15:0]   runs[ptt_pkg::SLOTS];
    bit [31:0]   now_cnt;
    bit [31:0]   id_cnt;
    timer_res_t  pending[$];
    int          errors;

    function void clear();
      foreach (vld[i]) vld[i] = 0;
      now_cnt = 0;
      id_cnt = 0;
      pending.delete();
      errors = 0;
    endfunction

    function int free_slots();
      int n;
      n = 0;
      foreach (vld[i]) if (!vld[i]) n++;
      return n;
    endfunction

    // Work out the results of an accepted transfer and update the shadow table.
    function void note_item(bit [1:0] k, bit [23:0] iv, bit [15:0] rc, bit [31:0] cid);
      int hit;
      bit [15:0] left;
      timer_res_t r;
      hit = -1;
      if (k == ptt_pkg::KIND_TICK) begin
        now_cnt++;
        for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
          if (!vld[i]) continue;
          if (now_cnt - dline[i] >= 32'h8000_0000) continue;  // deadline still ahead
          dline[i] = dline[i] + ival[i];
          left = 0;
          if (runs[i] != 0) begin
            runs[i]--;
            left = runs[i];
            if (left == 0) vld[i] = 0;
          end
          r = '{ptt_pkg::EV_FIRED, sid[i], left, 1'b0};
          pending.push_back(r);
        end
        r = '{ptt_pkg::EV_DONE, 32'd0, 16'd0, 1'b1};
        pending.push_back(r);
      end else if (k == ptt_pkg::KIND_SCHED) begin
        for (int i = 0; i < ptt_pkg::SLOTS; i++)
          if (!vld[i] && hit < 0) hit = i;
        if (hit < 0) begin
          r = '{ptt_pkg::EV_FULL, 32'd0, 16'd0, 1'b1};
        end else begin
          id_cnt++;
          vld[hit] = 1;
          sid[hit] = id_cnt;
          ival[hit] = iv;
          dline[hit] = now_cnt + iv;
          runs[hit] = rc;
          r = '{ptt_pkg::EV_SCHEDULED, id_cnt, 16'd0, 1'b1};
        end
        pending.push_back(r);
      end else if (k == ptt_pkg::KIND_CANCEL) begin
        for (int i = 0; i < ptt_pkg::SLOTS; i++)
          if (vld[i] && sid[i] == cid && hit < 0) hit = i;
        if (hit < 0) begin
          r = '{ptt_pkg::EV_NOTFOUND, 32'd0, 16'd0, 1'b1};
        end else begin
          vld[hit] = 0;
          r = '{ptt_pkg::EV_CANCELLED, cid, 16'd0, 1'b1};
        end
        pending.push_back(r);
      end
    endfunction

    function void check_result(timer_res_t got);
      timer_res_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result ev=%0d id=%0d runs=%0d last=%0b",
                   got.ev, got.id, got.runs, got.lst);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: exp ev=%0d id=%0d runs=%0d last=%0b, got ev=%0d id=%0d runs=%0d last=%0b",
                   exp_r.ev, exp_r.id, exp_r.runs, exp_r.lst,
                   got.ev, got.id, got.runs, got.lst);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [23:0] interval_ms;
  logic [15:0] run_count;
  logic [31:0] cancel_id;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  event_res;
  logic [31:0] result_id;
  logic [15:0] runs_left;
  logic        last;

  timer_scoreboard sb;
  bit  idle_on;       // random gaps enabled on both sides
  bit  hold_rx;       // long receiver hold-off requested

  periodic_task_timer_table i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .interval_ms(interval_ms), .run_count(run_count), .cancel_id(cancel_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .result_id(result_id), .runs_left(runs_left), .last(last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Send one item; holds valid and payload until the transfer.
  // Sender gaps come as bursts before the item is offered; back to back
  // items keep valid high and only swap the payload.
  task automatic send_item(bit [1:0] k, bit [23:0] iv, bit [15:0] rc, bit [31:0] cid);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    interval_ms <= iv;
    run_count   <= rc;
    cancel_id   <= cid;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, iv, rc, cid);
  endtask

  // Mostly take the id of a random slot if it is live, else a recent id; otherwise any value.
  function automatic bit [31:0] pick_cancel_id();
    int i;
    if ($urandom_range(0, 3) != 0) begin
      i = $urandom_range(0, ptt_pkg::SLOTS - 1);
      if (sb.vld[i]) return sb.sid[i];
      return sb.id_cnt - $urandom_range(0, 3);
    end
    return $urandom;
  endfunction

  // Random item; schedules get mostly short periods and counts so timers fire and free up.
  task automatic send_random();
    int sel;
    bit [23:0] iv;
    bit [15:0] rc;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      send_item(ptt_pkg::KIND_TICK, 24'($urandom), 16'($urandom), $urandom);
    end else if (sel < 78) begin
      case ($urandom_range(0, 5))
        0: iv = 24'($urandom);
        1: iv = 24'hFF_FFFF;
        default: iv = 24'($urandom_range(0, 6));
      endcase
      case ($urandom_range(0, 4))
        0: rc = 16'($urandom);
        1: rc = 16'd0;
        default: rc = 16'($urandom_range(1, 4));
      endcase
      send_item(ptt_pkg::KIND_SCHED, iv, rc, $urandom);
    end else if (sel < 96) begin
      send_item(ptt_pkg::KIND_CANCEL, 24'($urandom), 16'($urandom), pick_cancel_id());
    end else begin
      // unknown kind: ignored by the table
      send_item(ptt_pkg::KIND_NOP, 24'($urandom), 16'($urandom), $urandom);
    end
  endtask

  // Receiver: random ready bursts, a long hold-off on request, checks every transfer.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result('{event_res, result_id, runs_left, last});
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0 && gap == 0) begin
        gap = $urandom_range(1, 7);
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= (gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    interval_ms = '0;
    run_count = '0;
    cancel_id = '0;
    idle_on = 1'b0;
    hold_rx = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every kind, zero period, table full, not found, unknown kind.
    send_item(ptt_pkg::KIND_TICK, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ptt_pkg::KIND_SCHED, 24'd0, 16'd3, 32'd0);            // zero period
    send_item(ptt_pkg::KIND_SCHED, 24'd1, 16'd0, 32'hFFFF_FFFF);    // unlimited
    send_item(ptt_pkg::KIND_SCHED, 24'hFF_FFFF, 16'hFFFF, 32'd0);   // far deadline
    send_item(ptt_pkg::KIND_TICK, 24'd0, 16'd0, 32'd0);
    send_item(ptt_pkg::KIND_TICK, 24'd0, 16'd0, 32'd0);
    send_item(ptt_pkg::KIND_TICK, 24'd0, 16'd0, 32'd0);
    send_item(ptt_pkg::KIND_CANCEL, 24'hFF_FFFF, 16'hFFFF, 32'd2);
    send_item(ptt_pkg::KIND_CANCEL, 24'd0, 16'd0, 32'd2);           // already gone
    send_item(ptt_pkg::KIND_CANCEL, 24'd0, 16'd0, 32'hFFFF_FFFF);
    send_item(ptt_pkg::KIND_NOP, 24'd5, 16'd5, 32'd5);
    for (int i = 0; i < ptt_pkg::SLOTS; i++)                        // fill, then one more
      send_item(ptt_pkg::KIND_SCHED, 24'd2, 16'd1, 32'd0);

    // Long receiver hold-off while ticks keep coming, so the block backs up.
    hold_rx = 1'b1;
    repeat (6) send_item(ptt_pkg::KIND_TICK, 24'd0, 16'd0, 32'd0);

    idle_on = 1'b1;
    for (int n = 0; n < 400; n++) send_random();
    idle_on = 1'b0;
    for (int n = 0; n < 100; n++) send_random();
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Timeout well above the slowest correct run.
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

FILE: periodic_task_timer_table.f
rtl/ptt_pkg.sv
rtl/ptt_cell.sv
rtl/periodic_task_timer_table.sv
rtl/ptt_checker.sv
sim/tb_periodic_task_timer_table.sv
